// ----- rtl/scfa_pkg.sv -----
// ----------------------------------------------------------------------------
// scfa_pkg
// Shared types and constants of the size-class free-list allocator.
// ----------------------------------------------------------------------------
package scfa_pkg;

	localparam int SIZE_W         = 25;
	localparam int EXP_W          = 5;
	localparam int DATA_W         = 32;
	localparam int ALU_W          = 33;
	localparam int CFG_IDX_W      = 2;
	localparam int HEADER_BYTES   = 16;
	localparam int LINK_BYTES     = 16;
	localparam int BLOCK_OVERHEAD = HEADER_BYTES + LINK_BYTES;

	localparam logic [EXP_W-1:0]  RST_MIN_CLASS   = 5'd4;
	localparam logic [EXP_W-1:0]  RST_MAX_CLASS   = 5'd12;
	localparam logic [DATA_W-1:0] RST_ARENA_LIMIT = 32'd16777216;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN_CLASS   = 2'd0,
		CFG_MAX_CLASS   = 2'd1,
		CFG_ARENA_LIMIT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_TOO_LARGE = 2'd1,
		ST_FULL      = 2'd2,
		ST_IGNORED   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_POP   = 2'd0,
		OP_PUSH  = 2'd1,
		OP_CARVE = 2'd2
	} op_t;

	typedef struct packed {
		logic             sub;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

endpackage

// ----- rtl/scfa_if.sv -----
// ----------------------------------------------------------------------------
// scfa_if
// Valid/ready channels of the allocator: request beats in, result beats out.
// ----------------------------------------------------------------------------
interface scfa_req_if #(
	parameter int HW = 11
) ();
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [scfa_pkg::SIZE_W-1:0] size;
	logic [HW-1:0]               handle;

	modport source (output valid, mode, size, handle, input ready);
	modport sink   (input valid, mode, size, handle, output ready);
endinterface

interface scfa_rsp_if #(
	parameter int HW = 11,
	parameter int CW = 4
) ();
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [HW-1:0]               handle_out;
	logic [CW-1:0]               class_used;
	logic [scfa_pkg::DATA_W-1:0] total_bytes;
	logic [scfa_pkg::DATA_W-1:0] idle_bytes;
	logic [HW-1:0]               block_count;

	modport source (output valid, status, handle_out, class_used, total_bytes, idle_bytes,
		block_count, input ready);
	modport sink   (input valid, status, handle_out, class_used, total_bytes, idle_bytes,
		block_count, output ready);
endinterface

// ----- rtl/scfa_alu.sv -----
// ----------------------------------------------------------------------------
// scfa_alu
// Shared add/subtract unit; the top bit of the result flags a borrow on a subtract and a carry on an add.
// ----------------------------------------------------------------------------
module scfa_alu (
	input  scfa_pkg::alu_req_t           op,
	output logic [scfa_pkg::ALU_W:0]     res
);

	assign res = {1'b0, op.a} + ({1'b0, op.b} ^ {(scfa_pkg::ALU_W + 1){op.sub}})
		+ (scfa_pkg::ALU_W + 1)'(op.sub);

endmodule

// ----- rtl/size_class_freelist_allocator.sv -----
// ----------------------------------------------------------------------------
// size_class_freelist_allocator
// Power-of-two size-class allocator with one free list per class.
// ----------------------------------------------------------------------------
// One request is worked on at a time. The class exponent is found by a
// shift-and-count loop over the bits of (size - HEADER_BYTES - 1), and the
// block's arithmetic (carved bytes, arena check, idle bytes) runs one step a
// cycle through a single shared add/subtract unit. A pop reads the next link
// from the link memory in an extra state, S_LINK. The result is held in an
// output register, so a new request is taken while the last result waits.
// The link memory holds no reset value; the list heads clear at reset.
module size_class_freelist_allocator #(
	parameter int NUM_CLASSES = 16,
	parameter int MAX_BLOCKS  = 1024,
	localparam int HW = $clog2(MAX_BLOCKS + 1),
	localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1,
	localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [scfa_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [scfa_pkg::DATA_W-1:0]    cfg_wdata,
	scfa_req_if.sink                       req,
	scfa_rsp_if.source                     rsp
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_SIZE     = 9'b000000010,
		S_SCAN     = 9'b000000100,
		S_CLASS    = 9'b000001000,
		S_DISPATCH = 9'b000010000,
		S_LINK     = 9'b000100000,
		S_ADD      = 9'b001000000,
		S_CHECK    = 9'b010000000,
		S_DONE     = 9'b100000000
	} state_t;

	state_t state_q;

	logic [scfa_pkg::EXP_W-1:0]  min_class_q;
	logic [scfa_pkg::EXP_W-1:0]  max_class_q;
	logic [scfa_pkg::DATA_W-1:0] arena_limit_q;

	logic [HW-1:0]               heads_q [NUM_CLASSES];
	logic [HW-1:0]               links_mem [MAX_BLOCKS];
	logic [HW-1:0]               link_rd_q;
	logic [HW-1:0]               carved_blocks_q;
	logic [scfa_pkg::DATA_W-1:0] carved_bytes_q;
	logic [scfa_pkg::DATA_W-1:0] free_bytes_q;

	logic                        mode_q;
	logic [scfa_pkg::SIZE_W-1:0] size_q;
	logic [HW-1:0]               handle_q;
	logic [scfa_pkg::SIZE_W-1:0] v_q;
	logic [scfa_pkg::EXP_W-1:0]  e_q;
	logic                        too_large_q;
	logic [CW-1:0]               cls_q;
	logic [scfa_pkg::DATA_W-1:0] bytes_q;
	logic [scfa_pkg::ALU_W-1:0]  acc_q;
	scfa_pkg::op_t               op_q;
	scfa_pkg::status_t           status_q;
	logic [HW-1:0]               hout_q;

	logic                        out_valid_q;
	scfa_pkg::status_t           out_status_q;
	logic [HW-1:0]               out_handle_q;
	logic [CW-1:0]               out_class_q;
	logic [scfa_pkg::DATA_W-1:0] out_total_q;
	logic [scfa_pkg::DATA_W-1:0] out_idle_q;
	logic [HW-1:0]               out_count_q;

	scfa_pkg::alu_req_t          alu_op;
	logic [scfa_pkg::ALU_W:0]    alu_res;
	logic                        alu_neg;

	logic [scfa_pkg::EXP_W-1:0]  e_clamp;
	logic [scfa_pkg::EXP_W-1:0]  cls_diff;
	logic                        too_large;
	logic [HW-1:0]               head;
	logic                        free_bad;
	logic                        blocks_full;
	logic                        out_load;
	logic                        link_we;
	logic                        link_re;
	logic [AW-1:0]               link_wa;
	logic [AW-1:0]               link_ra;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_class_q   <= scfa_pkg::RST_MIN_CLASS;
			max_class_q   <= scfa_pkg::RST_MAX_CLASS;
			arena_limit_q <= scfa_pkg::RST_ARENA_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				scfa_pkg::CFG_MIN_CLASS:   min_class_q   <= cfg_wdata[scfa_pkg::EXP_W-1:0];
				scfa_pkg::CFG_MAX_CLASS:   max_class_q   <= cfg_wdata[scfa_pkg::EXP_W-1:0];
				scfa_pkg::CFG_ARENA_LIMIT: arena_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// shared arithmetic unit
	always_comb begin
		alu_op.sub = 1'b1;
		alu_op.a   = '0;
		alu_op.b   = '0;
		if (state_q == S_SIZE) begin
			alu_op.a = scfa_pkg::ALU_W'(size_q);
			alu_op.b = scfa_pkg::ALU_W'(scfa_pkg::HEADER_BYTES + 1);
		end else if (state_q == S_ADD) begin
			alu_op.b = scfa_pkg::ALU_W'(bytes_q);
			case (op_q)
				scfa_pkg::OP_POP: begin
					alu_op.a = scfa_pkg::ALU_W'(free_bytes_q);
				end
				scfa_pkg::OP_PUSH: begin
					alu_op.sub = 1'b0;
					alu_op.a   = scfa_pkg::ALU_W'(free_bytes_q);
				end
				default: begin
					alu_op.sub = 1'b0;
					alu_op.a   = scfa_pkg::ALU_W'(carved_bytes_q);
				end
			endcase
		end else if (state_q == S_CHECK) begin
			alu_op.a = scfa_pkg::ALU_W'(arena_limit_q);
			alu_op.b = acc_q;
		end
	end

	scfa_alu u_alu (
		.op  (alu_op),
		.res (alu_res)
	);

	assign alu_neg = alu_res[scfa_pkg::ALU_W];

	// class selection and request checks
	assign e_clamp     = (e_q < min_class_q) ? min_class_q : e_q;
	assign cls_diff    = e_clamp - min_class_q;
	assign too_large   = (e_clamp > max_class_q) ||
		({1'b0, cls_diff} >= (scfa_pkg::EXP_W + 1)'(NUM_CLASSES));
	assign head        = heads_q[cls_q];
	assign free_bad    = (handle_q == '0) || (handle_q > carved_blocks_q);
	assign blocks_full = carved_blocks_q >= HW'(MAX_BLOCKS);
	assign out_load    = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	assign link_re = (state_q == S_DISPATCH) && !too_large_q &&
		(mode_q == scfa_pkg::MODE_ALLOC) && (head != '0);
	assign link_we = (state_q == S_DISPATCH) && !too_large_q &&
		(mode_q == scfa_pkg::MODE_FREE) && !free_bad;
	assign link_ra = AW'(head - HW'(1));
	assign link_wa = AW'(handle_q - HW'(1));

	// link memory
	always_ff @(posedge clk) begin
		if (link_we) begin
			links_mem[link_wa] <= head;
		end
		if (link_re) begin
			link_rd_q <= links_mem[link_ra];
		end
	end

	// sequencer and allocator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			out_valid_q     <= 1'b0;
			carved_blocks_q <= '0;
			carved_bytes_q  <= '0;
			free_bytes_q    <= '0;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				heads_q[i] <= '0;
			end
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) state_q <= S_SIZE;
				end
				S_SIZE: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (v_q == '0) state_q <= S_CLASS;
				end
				S_CLASS: begin
					state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					if (too_large_q) begin
						state_q <= S_DONE;
					end else if (mode_q == scfa_pkg::MODE_ALLOC) begin
						if (head != '0) state_q <= S_LINK;
						else if (blocks_full) state_q <= S_DONE;
						else state_q <= S_ADD;
					end else if (free_bad) begin
						state_q <= S_DONE;
					end else begin
						heads_q[cls_q] <= handle_q;
						state_q        <= S_ADD;
					end
				end
				S_LINK: begin
					heads_q[cls_q] <= link_rd_q;
					state_q        <= S_ADD;
				end
				S_ADD: begin
					case (op_q)
						scfa_pkg::OP_POP: begin
							free_bytes_q <= alu_neg ? '0 : alu_res[scfa_pkg::DATA_W-1:0];
							state_q      <= S_DONE;
						end
						scfa_pkg::OP_PUSH: begin
							free_bytes_q <= alu_res[scfa_pkg::DATA_W] ? '1 :
								alu_res[scfa_pkg::DATA_W-1:0];
							state_q      <= S_DONE;
						end
						default: begin
							state_q <= S_CHECK;
						end
					endcase
				end
				S_CHECK: begin
					if (!alu_neg) begin
						carved_bytes_q  <= acc_q[scfa_pkg::DATA_W-1:0];
						carved_blocks_q <= carved_blocks_q + HW'(1);
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_load) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					mode_q   <= req.mode;
					size_q   <= req.size;
					handle_q <= req.handle;
				end
			end
			S_SIZE: begin
				v_q <= alu_neg ? '0 : alu_res[scfa_pkg::SIZE_W-1:0];
				e_q <= '0;
			end
			S_SCAN: begin
				if (v_q != '0) begin
					v_q <= v_q >> 1;
					e_q <= e_q + scfa_pkg::EXP_W'(1);
				end
			end
			S_CLASS: begin
				too_large_q <= too_large;
				cls_q       <= too_large ? '0 : cls_diff[CW-1:0];
				bytes_q     <= (scfa_pkg::DATA_W'(1) << e_clamp) +
					scfa_pkg::DATA_W'(scfa_pkg::BLOCK_OVERHEAD);
				status_q    <= too_large ? scfa_pkg::ST_TOO_LARGE : scfa_pkg::ST_OK;
				hout_q      <= '0;
			end
			S_DISPATCH: begin
				if (!too_large_q) begin
					if (mode_q == scfa_pkg::MODE_ALLOC) begin
						if (head != '0) begin
							op_q   <= scfa_pkg::OP_POP;
							hout_q <= head;
						end else if (blocks_full) begin
							status_q <= scfa_pkg::ST_FULL;
						end else begin
							op_q <= scfa_pkg::OP_CARVE;
						end
					end else if (free_bad) begin
						status_q <= scfa_pkg::ST_IGNORED;
					end else begin
						op_q <= scfa_pkg::OP_PUSH;
					end
				end
			end
			S_ADD: begin
				acc_q <= alu_res[scfa_pkg::ALU_W-1:0];
			end
			S_CHECK: begin
				if (alu_neg) status_q <= scfa_pkg::ST_FULL;
				else hout_q <= carved_blocks_q + HW'(1);
			end
			S_DONE: begin
				if (out_load) begin
					out_status_q <= status_q;
					out_handle_q <= hout_q;
					out_class_q  <= cls_q;
					out_total_q  <= carved_bytes_q;
					out_idle_q   <= free_bytes_q;
					out_count_q  <= carved_blocks_q;
				end
			end
			default: ;
		endcase
	end

	assign req.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.handle_out  = out_handle_q;
	assign rsp.class_used  = out_class_q;
	assign rsp.total_bytes = out_total_q;
	assign rsp.idle_bytes  = out_idle_q;
	assign rsp.block_count = out_count_q;

	a_block_bound: assert property (@(posedge clk) disable iff (!arst_n)
		carved_blocks_q <= HW'(MAX_BLOCKS))
		else $error("carved block count beyond table size");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == S_SIZE)
		else $error("accepted beat did not start the sequencer");

	a_head_carved: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DISPATCH && mode_q == scfa_pkg::MODE_ALLOC && !too_large_q &&
		head != '0 |-> head <= carved_blocks_q)
		else $error("free list head names a block never carved");

	a_check_carve: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> op_q == scfa_pkg::OP_CARVE && $past(state_q) == S_ADD)
		else $error("arena check outside a carve");

endmodule

// ----- bench/size_class_freelist_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// size_class_freelist_allocator_tb
// Self-checking bench for the size-class allocator. A ledger class mirrors the
// free lists, carved totals and idle bytes, predicts one result per request
// and checks every result beat in order. Directed requests hit the class and
// free corner cases. Random traffic runs under several register settings and
// under changing backpressure. A final pass saturates the idle count.
// ----------------------------------------------------------------------------
module size_class_freelist_allocator_tb;

	localparam int NUM_CLASSES = 16;
	localparam int MAX_BLOCKS  = 1024;
	localparam int HW          = $clog2(MAX_BLOCKS + 1);
	localparam int CW          = $clog2(NUM_CLASSES);
	localparam int CLK_PERIOD  = 8;
	localparam int DRAIN_WAIT  = 40;

	typedef struct packed {
		scfa_pkg::status_t           status;
		logic [HW-1:0]               handle_out;
		logic [CW-1:0]               class_used;
		logic [scfa_pkg::DATA_W-1:0] total_bytes;
		logic [scfa_pkg::DATA_W-1:0] idle_bytes;
		logic [HW-1:0]               block_count;
	} grant_t;

	class allocator_ledger;
		int unsigned     lo_exp;
		int unsigned     hi_exp;
		longint unsigned arena;
		longint unsigned carved;
		longint unsigned idle;
		int unsigned     blocks;
		logic [HW-1:0]   heads [NUM_CLASSES];
		logic [HW-1:0]   links [MAX_BLOCKS];
		grant_t          pending_grants [$];
		int unsigned     n_checked;
		int unsigned     n_bad;
		int unsigned     n_carve;
		int unsigned     n_pop;
		int unsigned     n_push;
		int unsigned     n_status [4];

		function new();
			lo_exp = scfa_pkg::RST_MIN_CLASS;
			hi_exp = scfa_pkg::RST_MAX_CLASS;
			arena = scfa_pkg::RST_ARENA_LIMIT;
			carved = 0;
			idle = 0;
			blocks = 0;
			foreach (heads[i]) heads[i] = '0;
		endfunction

		function void configure(scfa_pkg::cfg_idx_t idx, logic [scfa_pkg::DATA_W-1:0] v);
			case (idx)
				scfa_pkg::CFG_MIN_CLASS: lo_exp = v[scfa_pkg::EXP_W-1:0];
				scfa_pkg::CFG_MAX_CLASS: hi_exp = v[scfa_pkg::EXP_W-1:0];
				scfa_pkg::CFG_ARENA_LIMIT: arena = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return pending_grants.size();
		endfunction

		function void note_failure(string msg);
			n_bad++;
			if (n_bad <= 10)
				$display("%s", msg);
		endfunction

		function void note_request(logic m, logic [scfa_pkg::SIZE_W-1:0] sz, logic [HW-1:0] h);
			grant_t                      g;
			logic [scfa_pkg::SIZE_W-1:0] pay;
			int unsigned                 ex;
			int unsigned                 cls;
			longint unsigned             blk;
			logic [HW-1:0]               top;
			g.status = scfa_pkg::ST_OK;
			g.handle_out = '0;
			cls = 0;
			pay = (sz > scfa_pkg::HEADER_BYTES) ? sz - scfa_pkg::HEADER_BYTES : '0;
			ex = 0;
			while (ex < 40 && (64'd1 << ex) < pay)
				ex++;
			if (ex < lo_exp)
				ex = lo_exp;
			if (ex > hi_exp || ex - lo_exp >= NUM_CLASSES) begin
				g.status = scfa_pkg::ST_TOO_LARGE;
			end else begin
				blk = (64'd1 << ex) + scfa_pkg::BLOCK_OVERHEAD;
				cls = ex - lo_exp;
				if (m == scfa_pkg::MODE_ALLOC) begin
					top = heads[cls];
					if (top != 0) begin
						heads[cls] = links[top - 1];
						g.handle_out = top;
						idle = (idle >= blk) ? idle - blk : 0;
						n_pop++;
					end else if (blocks >= MAX_BLOCKS || carved + blk > arena) begin
						g.status = scfa_pkg::ST_FULL;
					end else begin
						carved = carved + blk;
						blocks++;
						g.handle_out = HW'(blocks);
						n_carve++;
					end
				end else begin
					if (h == 0 || h > blocks || h > MAX_BLOCKS) begin
						g.status = scfa_pkg::ST_IGNORED;
					end else begin
						links[h - 1] = heads[cls];
						heads[cls] = h;
						idle = (idle + blk > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : idle + blk;
						n_push++;
					end
				end
			end
			g.class_used = CW'(cls);
			g.total_bytes = scfa_pkg::DATA_W'(carved);
			g.idle_bytes = scfa_pkg::DATA_W'(idle);
			g.block_count = HW'(blocks);
			n_status[g.status]++;
			pending_grants.push_back(g);
		endfunction

		function void check_result(grant_t got);
			grant_t want;
			n_checked++;
			if (pending_grants.size() == 0) begin
				note_failure($sformatf("beat %0d: result with no request waiting", n_checked));
				return;
			end
			want = pending_grants.pop_front();
			if (got !== want)
				note_failure({$sformatf("beat %0d: expected st%0d h%0d c%0d bytes %0d idle %0d",
					n_checked, want.status, want.handle_out, want.class_used,
					want.total_bytes, want.idle_bytes),
					$sformatf(" blocks %0d, got st%0d h%0d c%0d bytes %0d idle %0d blocks %0d",
					want.block_count, got.status, got.handle_out, got.class_used,
					got.total_bytes, got.idle_bytes, got.block_count)});
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	scfa_pkg::cfg_idx_t          cfg_idx;
	logic [scfa_pkg::DATA_W-1:0] cfg_wdata;
	int                          src_idle_pct;
	int                          sink_idle_pct;
	bit                          hold_rsp;
	grant_t                      seen;
	allocator_ledger             ledger;

	scfa_req_if #(.HW(HW)) req_ch ();
	scfa_rsp_if #(.HW(HW), .CW(CW)) rsp_ch ();

	size_class_freelist_allocator #(
		.NUM_CLASSES(NUM_CLASSES),
		.MAX_BLOCKS (MAX_BLOCKS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (hold_rsp)
			rsp_ch.ready <= 1'b0;
		else
			rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && req_ch.valid && req_ch.ready)
			ledger.note_request(req_ch.mode, req_ch.size, req_ch.handle);
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			seen.status = scfa_pkg::status_t'(rsp_ch.status);
			seen.handle_out = rsp_ch.handle_out;
			seen.class_used = rsp_ch.class_used;
			seen.total_bytes = rsp_ch.total_bytes;
			seen.idle_bytes = rsp_ch.idle_bytes;
			seen.block_count = rsp_ch.block_count;
			ledger.check_result(seen);
		end
	end

	task automatic send_req(input logic m, input logic [scfa_pkg::SIZE_W-1:0] s,
			input logic [HW-1:0] h);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.mode <= m;
		req_ch.size <= s;
		req_ch.handle <= h;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic apply_config(input logic [scfa_pkg::EXP_W-1:0] lo,
			input logic [scfa_pkg::EXP_W-1:0] hi, input logic [scfa_pkg::DATA_W-1:0] lim);
		settle();
		cfg_we <= 1'b1;
		cfg_idx <= scfa_pkg::CFG_MIN_CLASS;
		cfg_wdata <= scfa_pkg::DATA_W'(lo);
		ledger.configure(scfa_pkg::CFG_MIN_CLASS, scfa_pkg::DATA_W'(lo));
		@(posedge clk);
		cfg_idx <= scfa_pkg::CFG_MAX_CLASS;
		cfg_wdata <= scfa_pkg::DATA_W'(hi);
		ledger.configure(scfa_pkg::CFG_MAX_CLASS, scfa_pkg::DATA_W'(hi));
		@(posedge clk);
		cfg_idx <= scfa_pkg::CFG_ARENA_LIMIT;
		cfg_wdata <= lim;
		ledger.configure(scfa_pkg::CFG_ARENA_LIMIT, lim);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly small classes, sometimes up to just past the largest allowed one
	function automatic logic [scfa_pkg::SIZE_W-1:0] pick_size();
		int unsigned top;
		int unsigned ex;
		top = (ledger.hi_exp < 24) ? ledger.hi_exp + 1 : 24;
		if ($urandom_range(3) != 0 && top > 10)
			top = 10;
		ex = $urandom_range(top, 0);
		if (ex == 0)
			return scfa_pkg::SIZE_W'($urandom_range(scfa_pkg::HEADER_BYTES + 1, 0));
		return scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES +
			$urandom_range(1 << ex, (1 << (ex - 1)) + 1));
	endfunction

	task automatic random_burst(input int n);
		int          r;
		int unsigned top;
		repeat (n) begin
			r = $urandom_range(99);
			top = (ledger.blocks > 0) ? ledger.blocks : 1;
			if (r < 55)
				send_req(scfa_pkg::MODE_ALLOC, pick_size(), HW'($urandom()));
			else if (r < 88)
				send_req(scfa_pkg::MODE_FREE, pick_size(), HW'($urandom_range(top, 1)));
			else if (r < 94)
				send_req(scfa_pkg::MODE_FREE, scfa_pkg::SIZE_W'($urandom()), HW'($urandom()));
			else
				send_req(scfa_pkg::MODE_ALLOC, scfa_pkg::SIZE_W'($urandom()), HW'($urandom()));
		end
	endtask

	initial begin
		#(CLK_PERIOD * 600000);
		$display("size_class_freelist_allocator: mismatch");
		$finish;
	end

	initial begin
		ledger = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = scfa_pkg::CFG_MIN_CLASS;
		cfg_wdata = '0;
		hold_rsp = 1'b0;
		src_idle_pct = 26;
		sink_idle_pct = 76;
		req_ch.valid = 1'b0;
		req_ch.mode = scfa_pkg::MODE_ALLOC;
		req_ch.size = '0;
		req_ch.handle = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: small sizes, class edges, null, invalid and double free
		send_req(scfa_pkg::MODE_ALLOC, '0, '0);
		send_req(scfa_pkg::MODE_ALLOC, scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES), '0);
		send_req(scfa_pkg::MODE_ALLOC, scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES + 1), '0);
		send_req(scfa_pkg::MODE_ALLOC, scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES + 4096), '0);
		send_req(scfa_pkg::MODE_ALLOC, scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES + 4097), '0);
		send_req(scfa_pkg::MODE_ALLOC, '1, '1);
		send_req(scfa_pkg::MODE_FREE, scfa_pkg::SIZE_W'(32), '0);
		send_req(scfa_pkg::MODE_FREE, '0, '1);
		send_req(scfa_pkg::MODE_FREE, '0, HW'(5));
		send_req(scfa_pkg::MODE_FREE, '0, HW'(1));
		send_req(scfa_pkg::MODE_FREE, '0, HW'(1));
		send_req(scfa_pkg::MODE_FREE,
			scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES + (1 << 24)), HW'(4));
		repeat (3) send_req(scfa_pkg::MODE_ALLOC, '0, '0);

		// widest window: class index past the table
		apply_config(5'd0, 5'd24, scfa_pkg::RST_ARENA_LIMIT);
		send_req(scfa_pkg::MODE_ALLOC, scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES + 65536), '0);
		send_req(scfa_pkg::MODE_ALLOC, scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES + 32768), '0);
		send_req(scfa_pkg::MODE_FREE, scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES + 32768),
			HW'(2));

		// min above max
		apply_config(5'd20, 5'd5, scfa_pkg::RST_ARENA_LIMIT);
		send_req(scfa_pkg::MODE_ALLOC, '0, '0);
		send_req(scfa_pkg::MODE_FREE, '0, HW'(1));

		// no arena left: carve fails, pop still works
		apply_config(5'd4, 5'd12, 32'd0);
		send_req(scfa_pkg::MODE_ALLOC, scfa_pkg::SIZE_W'(100), '0);
		send_req(scfa_pkg::MODE_ALLOC, '0, '0);

		apply_config(5'd3, 5'd14, 32'hFFFF_FFFF);
		random_burst(50);

		src_idle_pct = 76;
		sink_idle_pct = 26;
		apply_config(5'd0, 5'd10, 32'(ledger.carved + 5000));
		random_burst(40);

		src_idle_pct = 0;
		sink_idle_pct = 0;
		apply_config(5'd5, 5'd20, 32'hFFFF_FFFF);
		fork
			begin
				@(negedge clk);
				hold_rsp = 1'b1;
				repeat (400) @(negedge clk);
				hold_rsp = 1'b0;
			end
			random_burst(30);
		join
		random_burst(20);

		// repeated frees of the largest class drive idle bytes into saturation
		apply_config(5'd9, 5'd24, 32'hFFFF_FFFF);
		repeat (258) send_req(scfa_pkg::MODE_FREE,
			scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES + (1 << 24)), HW'(1));
		repeat (3) send_req(scfa_pkg::MODE_ALLOC,
			scfa_pkg::SIZE_W'(scfa_pkg::HEADER_BYTES + (1 << 24)), '0);
		send_req(scfa_pkg::MODE_FREE, '0, HW'(MAX_BLOCKS));
		send_req(scfa_pkg::MODE_ALLOC, '0, '0);

		settle();
		if (ledger.pending() != 0)
			ledger.note_failure($sformatf("%0d results never arrived", ledger.pending()));
		$display("run covered %0d requests: %0d carved, %0d popped, %0d pushed, %0d ok",
			ledger.n_checked, ledger.n_carve, ledger.n_pop, ledger.n_push,
			ledger.n_status[scfa_pkg::ST_OK]);
		$display("refusals: %0d too large, %0d full, %0d ignored; final block count %0d",
			ledger.n_status[scfa_pkg::ST_TOO_LARGE], ledger.n_status[scfa_pkg::ST_FULL],
			ledger.n_status[scfa_pkg::ST_IGNORED], ledger.blocks);
		if (ledger.n_bad == 0)
			$display("size_class_freelist_allocator: match");
		else
			$display("size_class_freelist_allocator: mismatch");
		$finish;
	end
endmodule
